// File: rtl/cihc_pkg.sv
// Shared types and constants for the compressed image header checker.
`timescale 1ns / 1ps

package cihc_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 4;
  localparam int IMAGE_W   = 46;
  localparam int SPAN_W    = 63;
  localparam int SEGCNT_W  = 20;
  localparam int SHIFT_W   = 64;
  localparam int RESULT_W  = STATUS_W + IMAGE_W + SPAN_W + SEGCNT_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  localparam int NAME_LEN       = 36;
  localparam int SEG_FIELD_END  = 'h27;
  localparam int CNT_FIELD_END  = 'h2B;
  localparam int LAST_FIELD_END = 'h2F;
  localparam int INDEX_START    = 'h30;
  localparam int MIN_STEP       = 14;
  localparam int MIN_SPAN       = INDEX_START + 8;

  localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h6C;
  localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h7A;
  localparam logic [BYTE_W-1:0] MAGIC_2 = 8'h6D;
  localparam logic [BYTE_W-1:0] MAGIC_3 = 8'h61;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 4'd0,
    ST_SPAN_SHORT   = 4'd1,
    ST_BAD_NAME     = 4'd2,
    ST_SEG_SIZE     = 4'd3,
    ST_ENTRY_COUNT  = 4'd4,
    ST_LAST_SIZE    = 4'd5,
    ST_INDEX_SPAN   = 4'd6,
    ST_ENTRY0       = 4'd7,
    ST_ENTRY_LARGE  = 4'd8,
    ST_ENTRY_STEP   = 4'd9,
    ST_DATA_SPAN    = 4'd10
  } status_t;

  typedef struct packed {
    logic              first;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [SEGCNT_W-1:0] segment_count;
    logic [SPAN_W-1:0]   container_end;
    logic [IMAGE_W-1:0]  image_size;
    status_t             status;
  } result_t;

endpackage

// File: rtl/compressed_image_header_check.sv
// Top level of the compressed image header checker.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tdata: data_byte; tuser: first
//  out_    | output    | out_tvalid/tready  | tdata: status, image_size, container_end,
//          |           |                    |        segment_count
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data: container_span
//
// One byte per cycle unless the output stalls; verdicts go out via the result register.
// The input register and the result register each hold one transaction.
// Synchronous active-low reset; after reset bytes are dropped until a first mark.
// A stalled result register holds off the check stage and then the input side.
`timescale 1ns / 1ps

module compressed_image_header_check #(
  parameter int     MAX_ENTRIES = 1048576,
  parameter longint MAX_SEGMENT = 67108864
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [cihc_pkg::SPAN_W-1:0]         cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cihc_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // [0] first
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] status, [49:4] image_size, [112:50] container_end,
  // [132:113] segment_count, [135:133] zero
  output logic [cihc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import cihc_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     go;
  logic     emit;
  logic     can_load;
  result_t  result;
  result_t  out_result;

  assign in_item.first     = in_tuser;
  assign in_item.data_byte = in_tdata;
  assign go                = item_valid && can_load;
  assign out_tdata         = OUT_TDATA_W'(out_result);

  cihc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .pop        (go)
  );

  cihc_check #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .item        (item),
    .emit        (emit),
    .result      (result)
  );

  cihc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (go && emit),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

endmodule

// File: rtl/cihc_in_stage.sv
// Input register stage for container bytes.
`timescale 1ns / 1ps

module cihc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cihc_pkg::in_item_t in_item,
  output logic               item_valid,
  output cihc_pkg::in_item_t item,
  input  logic               pop
);
  import cihc_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || pop;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/cihc_check.sv
// Header field parser and index checker with per-stream state.
`timescale 1ns / 1ps

module cihc_check #(
  parameter int      MAX_ENTRIES = 1048576,
  parameter longint  MAX_SEGMENT = 67108864
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cihc_pkg::SPAN_W-1:0]   cfg_wr_data,
  input  logic                          go,
  input  cihc_pkg::in_item_t            item,
  output logic                          emit,
  output cihc_pkg::result_t             result
);
  import cihc_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = $clog2(MAX_SEGMENT + 1);
  localparam int PW = $clog2(INDEX_START + 8 * MAX_ENTRIES);
  localparam int XW = PW - 3;

  logic [SPAN_W-1:0]  span_r;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [SW-1:0]      seg_r, seg_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      last_r, last_nxt;
  logic [SHIFT_W-1:0] prevp_r, prevp_nxt;
  logic               done_r, done_nxt;
  logic [CW+SW-1:0]   prod_r;
  logic [SPAN_W-1:0]  doff_r;
  logic [SPAN_W-1:0]  room_r;
  logic               dfit_r;

  logic [PW-1:0]      p;
  logic [PW-1:0]      rel;
  logic [XW-1:0]      idx;
  logic [31:0]        v32;
  logic [BYTE_W-1:0]  want;
  logic [SHIFT_W-1:0] img_sum;

  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    seg_nxt   = seg_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    prevp_nxt = prevp_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    result    = '0;
    p         = item.first ? '0 : pos_r;
    rel       = p - PW'(INDEX_START);
    idx       = rel[PW-1:3];
    v32       = '0;
    want      = '0;
    img_sum   = SHIFT_W'(prod_r) + SHIFT_W'(last_r);

    if (item.first) begin
      pos_nxt   = '0;
      shift_nxt = '0;
      seg_nxt   = '0;
      cnt_nxt   = '0;
      last_nxt  = '0;
      prevp_nxt = '0;
      done_nxt  = 1'b0;
    end

    if (item.first && (span_r < SPAN_W'(MIN_SPAN))) begin
      emit          = 1'b1;
      result.status = ST_SPAN_SHORT;
      done_nxt      = 1'b1;
    end else if (item.first || !done_r) begin
      pos_nxt   = p + 1'b1;
      shift_nxt = {(item.first ? 56'd0 : shift_r[SHIFT_W-9:0]), item.data_byte};
      v32       = shift_nxt[31:0];
      if (p < PW'(NAME_LEN)) begin
        case (p)
          PW'(0):  want = MAGIC_0;
          PW'(1):  want = MAGIC_1;
          PW'(2):  want = MAGIC_2;
          PW'(3):  want = MAGIC_3;
          default: want = '0;
        endcase
        if (item.data_byte != want) begin
          emit          = 1'b1;
          result.status = ST_BAD_NAME;
        end
      end else if (p < PW'(INDEX_START)) begin
        if (p == PW'(SEG_FIELD_END)) begin
          seg_nxt = SW'(v32);
          if (v32 == '0 || {32'd0, v32} > 64'(MAX_SEGMENT)) begin
            emit          = 1'b1;
            result.status = ST_SEG_SIZE;
          end
        end else if (p == PW'(CNT_FIELD_END)) begin
          cnt_nxt = CW'(v32);
          if (v32 <= 32'd1 || {32'd0, v32} > 64'(MAX_ENTRIES)) begin
            emit          = 1'b1;
            result.status = ST_ENTRY_COUNT;
          end
        end else if (p == PW'(LAST_FIELD_END)) begin
          last_nxt = SW'(v32);
          if (v32 == '0 || v32 > 32'(seg_r)) begin
            emit          = 1'b1;
            result.status = ST_LAST_SIZE;
          end else if (!dfit_r) begin
            emit          = 1'b1;
            result.status = ST_INDEX_SPAN;
          end
        end
      end else if (rel[2:0] == 3'd7) begin
        if (shift_nxt[SHIFT_W-1]) begin
          emit          = 1'b1;
          result.status = ST_ENTRY_LARGE;
        end else if (idx == '0 && shift_nxt != '0) begin
          emit          = 1'b1;
          result.status = ST_ENTRY0;
        end else if (idx != '0 && shift_nxt < prevp_r) begin
          emit          = 1'b1;
          result.status = ST_ENTRY_STEP;
        end else begin
          prevp_nxt = shift_nxt + SHIFT_W'(MIN_STEP);
          if ((SHIFT_W'(idx) + 1'b1) >= SHIFT_W'(cnt_r)) begin
            emit = 1'b1;
            if (!dfit_r || shift_nxt[SPAN_W-1:0] > room_r) begin
              result.status = ST_DATA_SPAN;
            end else begin
              result.status        = ST_OK;
              result.image_size    = img_sum[IMAGE_W-1:0];
              result.container_end = doff_r + shift_nxt[SPAN_W-1:0];
              result.segment_count = SEGCNT_W'(cnt_r - 1'b1);
            end
          end
        end
      end
      if (emit) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r  <= '0;
      pos_r   <= '0;
      shift_r <= '0;
      seg_r   <= '0;
      cnt_r   <= '0;
      last_r  <= '0;
      prevp_r <= '0;
      done_r  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        span_r <= cfg_wr_data;
      end
      if (go) begin
        pos_r   <= pos_nxt;
        shift_r <= shift_nxt;
        seg_r   <= seg_nxt;
        cnt_r   <= cnt_nxt;
        last_r  <= last_nxt;
        prevp_r <= prevp_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (CW+SW)'((cnt_r - CW'(2)) * seg_r);
    doff_r <= SPAN_W'(INDEX_START) + (SPAN_W'(cnt_r) << 3);
    room_r <= span_r - doff_r;
    dfit_r <= doff_r <= span_r;
  end

endmodule

// File: rtl/cihc_out_stage.sv
// Result register stage for check verdicts.
`timescale 1ns / 1ps

module cihc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cihc_pkg::result_t result,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output cihc_pkg::result_t out_result
);
  import cihc_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      result_r <= result;
    end
  end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the compressed image header checker.
`timescale 1ns / 1ps

module testbench;
  import cihc_pkg::*;

  localparam int unsigned SEG_LIMIT      = 64 * 1024 * 1024;
  localparam int unsigned ENTRY_LIMIT    = 1 << 20;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_BYTES    = 490;
  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [SPAN_W-1:0]      cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;

  result_t    expected_verdicts[$];
  logic [7:0] frame[$];

  logic [SPAN_W-1:0] span_reg;
  int unsigned       hdr_pos;
  logic [63:0]       shift_reg;
  logic [63:0]       prev_entry;
  logic [31:0]       seg_size;
  logic [31:0]       entry_cnt;
  logic [31:0]       last_size;
  bit                verdict_done;

  compressed_image_header_check #(
    .MAX_ENTRIES (ENTRY_LIMIT),
    .MAX_SEGMENT (SEG_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic bit fits_within(logic [63:0] span, logic [63:0] offset,
                                     logic [63:0] size);
    return offset <= span && size <= span - offset;
  endfunction

  function automatic void push_verdict(status_t st, logic [63:0] img,
                                       logic [63:0] end_off, logic [63:0] segs);
    result_t r;
    r.status        = st;
    r.image_size    = img[IMAGE_W-1:0];
    r.container_end = end_off[SPAN_W-1:0];
    r.segment_count = segs[SEGCNT_W-1:0];
    expected_verdicts.push_back(r);
    verdict_done = 1'b1;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic first_mark);
    logic [63:0] pos;
    logic [63:0] rel;
    logic [63:0] span64;
    logic [63:0] cnt64;
    logic [63:0] data_off;
    logic [63:0] segs;
    logic [7:0]  want;
    span64 = {1'b0, span_reg};
    if (first_mark) begin
      hdr_pos      = 0;
      shift_reg    = '0;
      seg_size     = '0;
      entry_cnt    = '0;
      last_size    = '0;
      prev_entry   = '0;
      verdict_done = 1'b0;
      if (span64 < MIN_SPAN) begin
        push_verdict(ST_SPAN_SHORT, 0, 0, 0);
        return;
      end
    end else if (verdict_done) begin
      return;
    end
    pos       = hdr_pos;
    hdr_pos   = hdr_pos + 1;
    shift_reg = {shift_reg[55:0], b};
    if (pos < NAME_LEN) begin
      case (pos)
        0: want = MAGIC_0;
        1: want = MAGIC_1;
        2: want = MAGIC_2;
        3: want = MAGIC_3;
        default: want = '0;
      endcase
      if (b != want) push_verdict(ST_BAD_NAME, 0, 0, 0);
      return;
    end
    if (pos < INDEX_START) begin
      if (pos == SEG_FIELD_END) begin
        seg_size = shift_reg[31:0];
        if (seg_size == 0 || seg_size > SEG_LIMIT) push_verdict(ST_SEG_SIZE, 0, 0, 0);
      end else if (pos == CNT_FIELD_END) begin
        entry_cnt = shift_reg[31:0];
        if (entry_cnt <= 1 || entry_cnt > ENTRY_LIMIT) push_verdict(ST_ENTRY_COUNT, 0, 0, 0);
      end else if (pos == LAST_FIELD_END) begin
        last_size = shift_reg[31:0];
        cnt64     = {32'b0, entry_cnt};
        if (last_size == 0 || last_size > seg_size) begin
          push_verdict(ST_LAST_SIZE, 0, 0, 0);
        end else if (!fits_within(span64, INDEX_START, cnt64 << 3)) begin
          push_verdict(ST_INDEX_SPAN, 0, 0, 0);
        end
      end
      return;
    end
    rel = pos - INDEX_START;
    if (rel[2:0] != 3'd7) return;
    if (shift_reg[63]) begin
      push_verdict(ST_ENTRY_LARGE, 0, 0, 0);
      return;
    end
    if (rel[63:3] == 0) begin
      if (shift_reg != 0) begin
        push_verdict(ST_ENTRY0, 0, 0, 0);
        return;
      end
    end else if (shift_reg < prev_entry + MIN_STEP) begin
      push_verdict(ST_ENTRY_STEP, 0, 0, 0);
      return;
    end
    prev_entry = shift_reg;
    if (rel[63:3] + 1 >= entry_cnt) begin
      cnt64    = {32'b0, entry_cnt};
      data_off = INDEX_START + (cnt64 << 3);
      segs     = cnt64 - 1;
      if (!fits_within(span64, data_off, prev_entry)) begin
        push_verdict(ST_DATA_SPAN, 0, 0, 0);
      end else begin
        push_verdict(ST_OK, (segs - 1) * seg_size + last_size, data_off + prev_entry, segs);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] seen);
    $display("mismatch %s: expected %0h, got %0h", what, want, seen);
    error_count++;
  endtask

  task automatic check_verdict(result_t got);
    result_t exp_r;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("unexpected result, status", 0, got.status);
      return;
    end
    exp_r = expected_verdicts.pop_front();
    if (got.status !== exp_r.status)
      report_mismatch("status", exp_r.status, got.status);
    if (got.image_size !== exp_r.image_size)
      report_mismatch("image_size", exp_r.image_size, got.image_size);
    if (got.container_end !== exp_r.container_end)
      report_mismatch("container_end", exp_r.container_end, got.container_end);
    if (got.segment_count !== exp_r.segment_count)
      report_mismatch("segment_count", exp_r.segment_count, got.segment_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      span_reg     = '0;
      hdr_pos      = 0;
      shift_reg    = '0;
      seg_size     = '0;
      entry_cnt    = '0;
      last_size    = '0;
      prev_entry   = '0;
      verdict_done = 1'b1;
      expected_verdicts.delete();
    end else begin
      if (out_tvalid && out_tready) check_verdict(out_tdata[RESULT_W-1:0]);
      if (cfg_wr_en) span_reg = cfg_wr_data;
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic first_mark);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = first_mark;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(int from, int upto);
    for (int i = from; i < upto; i++) send_byte(frame[i], i == 0);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_span(logic [SPAN_W-1:0] value);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic void put_be(logic [63:0] value, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame.push_back(value[8*i +: 8]);
  endfunction

  function automatic void make_header(logic [31:0] seg, logic [31:0] cnt, logic [31:0] last);
    frame.delete();
    frame.push_back(MAGIC_0);
    frame.push_back(MAGIC_1);
    frame.push_back(MAGIC_2);
    frame.push_back(MAGIC_3);
    repeat (NAME_LEN - 4) frame.push_back(8'h00);
    put_be(seg, 4);
    put_be(cnt, 4);
    put_be(last, 4);
  endfunction

  function automatic logic [63:0] add_index(int count, int unsigned max_gap);
    logic [63:0] e;
    logic [63:0] prev;
    e    = '0;
    prev = '0;
    for (int i = 0; i < count; i++) begin
      put_be(e, 8);
      prev = e;
      e    = e + MIN_STEP + $urandom_range(max_gap);
    end
    return prev;
  endfunction

  function automatic void make_three_entry_frame(logic [63:0] e0, logic [63:0] e1,
                                                 logic [63:0] e2);
    make_header(512, 3, 7);
    put_be(e0, 8);
    put_be(e1, 8);
    put_be(e2, 8);
  endfunction

  function automatic void build_random_frame();
    logic [31:0]  seg;
    logic [31:0]  cnt;
    logic [31:0]  last;
    logic [63:0]  e;
    logic [63:0]  gap;
    int           n;
    int unsigned  roll;
    seg  = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, SEG_LIMIT);
    roll = $urandom_range(99);
    if (roll < 6) cnt = $urandom;
    else if (roll < 20) cnt = $urandom_range(7, 24);
    else cnt = $urandom_range(2, 6);
    last = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, seg);
    make_header(seg, cnt, last);
    n = (cnt <= 24) ? cnt : $urandom_range(0, 4);
    e = ($urandom_range(99) < 3) ? {$urandom, $urandom} : 64'd0;
    for (int i = 0; i < n; i++) begin
      put_be(e, 8);
      roll = $urandom_range(99);
      if (roll < 2) gap = $urandom_range(MIN_STEP - 1);
      else if (roll < 4) gap = {$urandom, $urandom};
      else gap = MIN_STEP + $urandom_range(200);
      e = e + gap;
    end
    if ($urandom_range(99) < 10) frame[$urandom_range(frame.size() - 1)] = $urandom;
  endfunction

  task automatic test_ignored_bytes();
    send_byte(MAGIC_0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_span_short();
    write_span(MIN_SPAN - 1);
    send_byte(MAGIC_0, 1'b1);
    send_byte(MAGIC_1, 1'b0);
    write_span('0);
    send_byte(8'hFF, 1'b1);
    write_span(MIN_SPAN);
    make_header(16, 2, 16);
    void'(add_index(2, 0));
    send_frame(0, frame.size());
  endtask

  task automatic test_name_field();
    int          spots[6] = '{0, 1, 2, 3, 4, NAME_LEN - 1};
    logic [63:0] last_e;
    write_span(SPAN_MAX);
    foreach (spots[i]) begin
      make_header(4096, 3, 100);
      last_e = add_index(3, 50);
      frame[spots[i]] = frame[spots[i]] ^ (8'h01 << (i % 8)) ^ 8'h80;
      send_frame(0, frame.size());
    end
  endtask

  task automatic test_header_fields();
    logic [31:0] seg_v[12]  = '{0, SEG_LIMIT + 1, 32'hFFFF_FFFF, SEG_LIMIT, 100, 100,
                                100, 100, 100, 100, 100, 1};
    logic [31:0] cnt_v[12]  = '{3, 3, 3, 3, 0, 1, ENTRY_LIMIT + 1, 32'hFFFF_FFFF,
                                3, 3, 3, 2};
    logic [31:0] last_v[12] = '{1, 1, 1, SEG_LIMIT, 1, 1, 1, 1, 0, 101, 100, 1};
    write_span(SPAN_MAX);
    foreach (seg_v[i]) begin
      make_header(seg_v[i], cnt_v[i], last_v[i]);
      void'(add_index((cnt_v[i] <= 8) ? cnt_v[i] : 2, 40));
      send_frame(0, frame.size());
    end
  endtask

  task automatic test_index_entries();
    write_span(SPAN_MAX);
    make_three_entry_frame(1, 100, 200);
    send_frame(0, frame.size());
    make_three_entry_frame(64'h8000_0000_0000_0000, 100, 200);
    send_frame(0, frame.size());
    make_three_entry_frame(0, 13, 40);
    send_frame(0, frame.size());
    make_three_entry_frame(0, 14, 27);
    send_frame(0, frame.size());
    make_three_entry_frame(0, 14, 28);
    send_frame(0, frame.size());
    make_three_entry_frame(0, 64'h7FFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(0, frame.size());
  endtask

  task automatic test_span_bounds();
    logic [63:0] last_e;
    write_span(SPAN_MAX);
    make_header(SEG_LIMIT, 2, SEG_LIMIT);
    put_be(0, 8);
    put_be({1'b0, SPAN_MAX} - 64, 8);
    send_frame(0, frame.size());
    make_header(SEG_LIMIT, 2, SEG_LIMIT);
    put_be(0, 8);
    put_be({1'b0, SPAN_MAX} - 63, 8);
    send_frame(0, frame.size());

    make_header(100, 4, 50);
    last_e = add_index(4, 20);
    write_span(INDEX_START + 32 + last_e);
    send_frame(0, frame.size());
    write_span(INDEX_START + 32 + last_e - 1);
    send_frame(0, frame.size());

    make_header(100, ENTRY_LIMIT, 50);
    write_span(INDEX_START + 8 * ENTRY_LIMIT - 1);
    send_frame(0, frame.size());
    write_span(INDEX_START + 8 * ENTRY_LIMIT);
    send_frame(0, frame.size());

    write_span(SPAN_MAX);
    make_header(200, 3, 9);
    void'(add_index(3, 30));
    send_frame(0, LAST_FIELD_END);
    write_span(MIN_SPAN);
    send_frame(LAST_FIELD_END, frame.size());
    write_span(SPAN_MAX);
    send_frame(0, INDEX_START + 23);
    write_span(INDEX_START + 24);
    send_frame(INDEX_START + 23, frame.size());
  endtask

  task automatic test_restart();
    write_span(SPAN_MAX);
    make_header(300, ENTRY_LIMIT, 5);
    void'(add_index(3, 10));
    send_frame(0, frame.size());
    make_header(300, 4, 5);
    void'(add_index(4, 10));
    send_frame(0, 20);
    send_frame(0, frame.size());
    send_frame(0, 10);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_traffic();
    int                idle_set[4]  = '{0, 75, 0, 25};
    int                stall_set[4] = '{0, 0, 75, 25};
    logic [SPAN_W-1:0] span_pick;
    int                start_count;
    int                cut;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: span_pick = SPAN_MAX;
        1: span_pick = {$urandom, $urandom};
        2: span_pick = $urandom_range(MIN_SPAN, 'h600);
        default: span_pick = $urandom_range('h200, 'hF_FFFF);
      endcase
      write_span(span_pick);
      idle_pct    = idle_set[ph];
      stall_pct   = stall_set[ph];
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_BYTES) begin
        build_random_frame();
        cut = ($urandom_range(99) < 8) ? $urandom_range(1, frame.size()) : frame.size();
        send_frame(0, cut);
        if ($urandom_range(99) < 10)
          repeat ($urandom_range(1, 8)) send_byte($urandom, 1'b0);
        if ($urandom_range(99) < 3) send_byte($urandom, 1'b1);
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_ignored_bytes();
    test_span_short();
    test_name_field();
    test_header_fields();
    test_index_entries();
    test_span_bounds();
    test_restart();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
